// ===== src/oafir_pkg.sv =====
// ----------------------------------------------------------------------------
// oafir_pkg: shared types and constants of the overlap-add FIR filter
// Payload structs, command codes, sequencer states and output rounding.
// ----------------------------------------------------------------------------
`default_nettype none

package oafir_pkg;

  localparam int unsigned FFT_LEN = 64;
  localparam int unsigned DEPTH   = FFT_LEN - 1;
  localparam int unsigned IDX_W   = $clog2(FFT_LEN);
  localparam int unsigned ACC_W   = 38;
  localparam logic [IDX_W-1:0] TAP_RESET = IDX_W'(32);

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_COEF   = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_FILL,
    ST_READ,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic               cmd;
    logic signed [15:0] sample_re;
    logic signed [15:0] sample_im;
    logic [IDX_W-1:0]   coef_index;
    logic signed [15:0] coef_value;
  } in_req_t;

  typedef struct packed {
    logic signed [15:0] out_re;
    logic signed [15:0] out_im;
    logic               last;
  } out_req_t;

  // control shared by every cell of the chain
  typedef struct packed {
    logic step;
    logic clr;
  } cell_ctrl_t;

  // round from Q15, half up, then saturate to 16 bits
  function automatic logic signed [15:0] round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-16:0] q;
    r = v + ACC_W'(16384);
    q = r[ACC_W-1:15];
    if (q > (ACC_W-15)'(32767)) begin
      round_sat = 16'sh7FFF;
    end else if (q < -(ACC_W-15)'(32768)) begin
      round_sat = 16'sh8000;
    end else begin
      round_sat = q[15:0];
    end
  endfunction

endpackage

`default_nettype wire

// ===== src/oafir_cell.sv =====
// ----------------------------------------------------------------------------
// oafir_cell: one tap of the transposed FIR chain
// Holds a tap and the pending partial sum for a sample some steps ahead;
// passes its sum to the lower neighbor on each step.
// ----------------------------------------------------------------------------
`default_nettype none

module oafir_cell import oafir_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire cell_ctrl_t              ctrl_i,
  input  wire logic                    active_i,
  input  wire logic                    tap_we_i,
  input  wire logic signed [15:0]      tap_i,
  input  wire logic signed [15:0]      x_re_i,
  input  wire logic signed [15:0]      x_im_i,
  input  wire logic signed [ACC_W-1:0] nb_re_i,
  input  wire logic signed [ACC_W-1:0] nb_im_i,
  output logic signed [ACC_W-1:0]      sum_re_o,
  output logic signed [ACC_W-1:0]      sum_im_o
);

  logic signed [15:0]      tap_q;
  logic signed [ACC_W-1:0] acc_re_q, acc_im_q;
  logic signed [15:0]      h;
  logic signed [31:0]      prod_re, prod_im;

  // taps beyond the count in use contribute nothing
  always_comb begin
    h        = active_i ? tap_q : 16'sd0;
    prod_re  = h * x_re_i;
    prod_im  = h * x_im_i;
    sum_re_o = acc_re_q + ACC_W'(prod_re);
    sum_im_o = acc_im_q + ACC_W'(prod_im);
  end

  // tap register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else if (tap_we_i) begin
      tap_q <= tap_i;
    end
  end

  // pending sum, loaded from the upper neighbor
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (ctrl_i.clr) begin
      acc_re_q <= '0;
      acc_im_q <= '0;
    end else if (ctrl_i.step) begin
      acc_re_q <= nb_re_i;
      acc_im_q <= nb_im_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/overlap_add_fir_filter.sv =====
// ----------------------------------------------------------------------------
// overlap_add_fir_filter: block FIR on complex samples, overlap-add output
// Collects a block, then runs it through a chain of tap cells as a burst.
// ----------------------------------------------------------------------------
// Sample requests are collected; once 64 minus the taps in use (tap_count, or 1
// when it is 0) samples are in, the block is read back from a single-port
// block store, each sample by a store read and then one step of the 63-cell
// chain, a stalled output holding the step, and each step yields one result,
// the last one marked. Coefficient requests apply from the next burst.
// Writing tap_count empties the partial block and clears all pending sums;
// while a tap_count write is offered, requests are held off.
`default_nettype none

module overlap_add_fir_filter import oafir_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_req_t          in_req_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_req_t              out_req_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [IDX_W-1:0] cfg_data_i
);

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     tap_cnt_q;
  logic [IDX_W-1:0]     fill_q, fill_d;
  logic [IDX_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [IDX_W-1:0]     m_eff, blk_len;
  logic [31:0]          store [DEPTH];
  logic [31:0]          rdata_q;
  logic                 out_valid_q;
  out_req_t             out_q;
  logic                 in_acc, cfg_acc, smp_acc, coef_acc, step, last_step;
  cell_ctrl_t           ctrl;
  logic signed [ACC_W-1:0] sum_re [DEPTH+1];
  logic signed [ACC_W-1:0] sum_im [DEPTH+1];

  // effective tap count and block length
  always_comb begin
    m_eff   = (tap_cnt_q == '0) ? IDX_W'(1) : tap_cnt_q;
    blk_len = IDX_W'(FFT_LEN) - m_eff;
  end

  // handshakes, a tap count write goes before any request
  always_comb begin
    in_stall_o  = (state_q != ST_FILL) || cfg_valid_i;
    cfg_ready_o = (state_q == ST_FILL);
    in_acc      = in_valid_i && !in_stall_o;
    cfg_acc     = cfg_valid_i && cfg_ready_o;
    smp_acc     = in_acc && (in_req_i.cmd == CMD_SAMPLE);
    coef_acc    = in_acc && (in_req_i.cmd == CMD_COEF);
    step        = (state_q == ST_EXEC) && (!out_valid_q || !out_stall_i);
    last_step   = step && (rd_ptr_q == blk_len - IDX_W'(1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_FILL: if (smp_acc && (fill_q + IDX_W'(1) == blk_len)) state_d = ST_READ;
      ST_READ: state_d = ST_EXEC;
      ST_EXEC: begin
        if (last_step) state_d = ST_FILL;
        else if (step) state_d = ST_READ;
      end
      default: state_d = ST_FILL;
    endcase
  end

  // counters
  always_comb begin
    fill_d   = fill_q;
    rd_ptr_d = rd_ptr_q;
    ctrl     = '{step: step, clr: cfg_acc};
    case (state_q)
      ST_FILL: begin
        if (cfg_acc) begin
          fill_d = '0;
        end else if (smp_acc) begin
          fill_d   = (fill_q + IDX_W'(1) == blk_len) ? '0 : fill_q + IDX_W'(1);
          rd_ptr_d = '0;
        end
      end
      ST_EXEC: if (step) rd_ptr_d = rd_ptr_q + IDX_W'(1);
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      tap_cnt_q   <= TAP_RESET;
      fill_q      <= '0;
      rd_ptr_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      rd_ptr_q <= rd_ptr_d;
      if (cfg_acc) tap_cnt_q <= cfg_data_i;
      if (step) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // block store, registered read
  always_ff @(posedge clk_i) begin
    if (smp_acc) store[fill_q] <= {in_req_i.sample_im, in_req_i.sample_re};
    if (state_q == ST_READ) rdata_q <= store[rd_ptr_q];
  end

  // chain of tap cells, top cell sees no pending sum
  assign sum_re[DEPTH] = '0;
  assign sum_im[DEPTH] = '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    oafir_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .active_i (IDX_W'(k) < m_eff),
      .tap_we_i (coef_acc && (in_req_i.coef_index == IDX_W'(k))),
      .tap_i    (in_req_i.coef_value),
      .x_re_i   (rdata_q[15:0]),
      .x_im_i   (rdata_q[31:16]),
      .nb_re_i  (sum_re[k+1]),
      .nb_im_i  (sum_im[k+1]),
      .sum_re_o (sum_re[k]),
      .sum_im_o (sum_im[k])
    );
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q.out_re <= round_sat(sum_re[0]);
      out_q.out_im <= round_sat(sum_im[0]);
      out_q.last   <= last_step;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

  // fill count stays inside the block while collecting
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL) |-> (fill_q < blk_len))
    else $error("fill count beyond block length");

  // a chain step always presents a result
  a_step_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> (out_valid_o && (out_req_o.last == $past(last_step))))
    else $error("chain step without result");

  // the final step of a burst returns to collecting with an empty block
  a_burst_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_step |=> (state_q == ST_FILL && fill_q == '0))
    else $error("burst end not back to fill");

endmodule

`default_nettype wire

// ===== verif/overlap_add_fir_filter_tb.sv =====
// ----------------------------------------------------------------------------
// overlap_add_fir_filter_tb: self-checking bench of the overlap-add FIR filter
// A scoreboard class mirrors tap, block and tail state and predicts each
// burst. It compares every output request against the oldest prediction
// while the tap count steps through several settings under random stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module overlap_add_fir_filter_tb;
  import oafir_pkg::*;

  localparam int unsigned HALF_PERIOD   = 2;
  localparam int unsigned RESET_CYCLES  = 4;
  localparam int unsigned RANDOM_ITEMS  = 380;
  localparam int unsigned DRAIN_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT   = 600000;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam int unsigned MODE_SEND_IDLE = 0;
  localparam int unsigned MODE_RECV_IDLE = 1;
  localparam int unsigned MODE_NO_IDLE   = 2;

  // tracks filter state and the queue of predicted output samples
  class fir_scoreboard;
    logic [IDX_W-1:0]   tap_reg;
    logic signed [15:0] taps[DEPTH];
    logic signed [15:0] blk_re[DEPTH];
    logic signed [15:0] blk_im[DEPTH];
    int unsigned        fill;
    longint             tail_re[DEPTH];
    longint             tail_im[DEPTH];
    out_req_t           pending[$];
    int unsigned        errors;

    function new();
      tap_reg = TAP_RESET;
      fill    = 0;
      errors  = 0;
      foreach (taps[i]) begin
        taps[i]    = '0;
        blk_re[i]  = '0;
        blk_im[i]  = '0;
        tail_re[i] = 0;
        tail_im[i] = 0;
      end
    endfunction

    // tap count write empties the partial block and drops the tails
    function void set_tap_count(logic [IDX_W-1:0] v);
      tap_reg = v;
      fill    = 0;
      foreach (tail_re[i]) begin
        tail_re[i] = 0;
        tail_im[i] = 0;
      end
    endfunction

    function int unsigned taps_in_use();
      int unsigned t;
      t = tap_reg;
      if (t < 1) t = 1;
      if (t > FFT_LEN - 1) t = FFT_LEN - 1;
      return t;
    endfunction

    // round half up from Q15, then clamp to 16 bits
    function logic signed [15:0] q15_round(longint v);
      longint q;
      q = (v + 16384) >>> 15;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q[15:0];
    endfunction

    function void note_request(in_req_t r);
      int unsigned m;
      int unsigned blk_len;
      longint      acc_re[FFT_LEN];
      longint      acc_im[FFT_LEN];
      out_req_t    o;
      if (r.cmd == CMD_COEF) begin
        if (r.coef_index < DEPTH) taps[r.coef_index] = r.coef_value;
        return;
      end
      m       = taps_in_use();
      blk_len = FFT_LEN - m;
      if (fill >= blk_len) fill = 0;
      blk_re[fill] = r.sample_re;
      blk_im[fill] = r.sample_im;
      fill++;
      if (fill < blk_len) return;
      // full linear convolution of the block, tail folded into the head
      for (int n = 0; n < FFT_LEN; n++) begin
        acc_re[n] = 0;
        acc_im[n] = 0;
        for (int k = 0; k < m && k <= n; k++) begin
          if (n - k < blk_len) begin
            acc_re[n] += longint'(taps[k]) * longint'(blk_re[n-k]);
            acc_im[n] += longint'(taps[k]) * longint'(blk_im[n-k]);
          end
        end
        if (n < m) begin
          acc_re[n] += tail_re[n];
          acc_im[n] += tail_im[n];
        end
      end
      for (int k = 0; k < m; k++) begin
        tail_re[k] = acc_re[blk_len+k];
        tail_im[k] = acc_im[blk_len+k];
      end
      for (int n = 0; n < blk_len; n++) begin
        o.out_re = q15_round(acc_re[n]);
        o.out_im = q15_round(acc_im[n]);
        o.last   = (n + 1 == blk_len);
        pending.push_back(o);
      end
      fill = 0;
    endfunction

    function void check_result(out_req_t got);
      out_req_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected output re=%0d im=%0d last=%0b",
                   got.out_re, got.out_im, got.last);
        return;
      end
      want = pending.pop_front();
      if (got.out_re !== want.out_re || got.out_im !== want.out_im ||
          got.last !== want.last) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("output differs: exp re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b",
                   want.out_re, want.out_im, want.last,
                   got.out_re, got.out_im, got.last);
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  in_req_t          in_req_i;
  logic             out_valid_o;
  logic             out_stall_i;
  out_req_t         out_req_o;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [IDX_W-1:0] cfg_data_i;

  fir_scoreboard filt_sb;
  int unsigned   idle_mode;
  int unsigned   items_sent;
  int unsigned   cycle_count;

  overlap_add_fir_filter dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_req_o  (out_req_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // clock
  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("overlap_add_fir_filter: mismatch");
      $finish;
    end
  end

  // receiver stall pattern, heavy while the sender idles lightly and back
  always @(posedge clk_i) begin
    if (idle_mode == MODE_SEND_IDLE) begin
      out_stall_i <= ($urandom_range(0, 99) < 76);
    end else if (idle_mode == MODE_RECV_IDLE) begin
      out_stall_i <= ($urandom_range(0, 99) < 33);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) filt_sb.check_result(out_req_o);
  end

  // one input request, held until accepted, then an optional gap
  task automatic send_request(in_req_t r);
    int unsigned pct;
    in_valid_i <= 1'b1;
    in_req_i   <= r;
    do @(posedge clk_i); while (in_stall_o);
    filt_sb.note_request(r);
    items_sent++;
    if (items_sent < 180) idle_mode = MODE_SEND_IDLE;
    else if (items_sent < 330) idle_mode = MODE_RECV_IDLE;
    else idle_mode = MODE_NO_IDLE;
    pct = (idle_mode == MODE_SEND_IDLE) ? 33 : (idle_mode == MODE_RECV_IDLE) ? 76 : 0;
    if ($urandom_range(0, 99) < pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  // wait until all predicted outputs are out and the block has settled
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (filt_sb.pending.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_tap_count(logic [IDX_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    filt_sb.set_tap_count(v);
  endtask

  function automatic in_req_t coef_req(int unsigned idx, int v);
    in_req_t r;
    r            = '0;
    r.cmd        = CMD_COEF;
    r.coef_index = idx[IDX_W-1:0];
    r.coef_value = v[15:0];
    r.sample_re  = $urandom();
    r.sample_im  = $urandom();
    return r;
  endfunction

  function automatic in_req_t sample_req(int re, int im);
    in_req_t r;
    r            = '0;
    r.cmd        = CMD_SAMPLE;
    r.sample_re  = re[15:0];
    r.sample_im  = im[15:0];
    r.coef_index = $urandom();
    r.coef_value = $urandom();
    return r;
  endfunction

  function automatic int rand_field();
    if ($urandom_range(0, 7) == 0) return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
    return int'($signed(16'($urandom())));
  endfunction

  // random mix: mostly samples, some coefficient writes, taps in use favored
  task automatic random_requests(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 5) == 0) begin
        if ($urandom_range(0, 3) == 0)
          send_request(coef_req($urandom_range(0, 63), rand_field()));
        else
          send_request(coef_req($urandom_range(0, filt_sb.taps_in_use() - 1), rand_field()));
      end else begin
        send_request(sample_req(rand_field(), rand_field()));
      end
    end
  endtask

  initial begin
    logic [IDX_W-1:0] settings[6];
    filt_sb     = new();
    idle_mode   = MODE_SEND_IDLE;
    items_sent  = 0;
    cycle_count = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    settings    = '{6'd32, 6'd0, 6'd63, 6'd1, 6'd45, 6'd7};
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: short blocks, extreme taps and samples, ignored tap index
    write_tap_count(6'd60);
    send_request(coef_req(0, 32767));
    send_request(coef_req(1, -32768));
    send_request(coef_req(2, 16384));
    send_request(coef_req(59, -1));
    send_request(coef_req(62, 12345));
    send_request(coef_req(63, 1234));
    send_request(sample_req(32767, -32768));
    send_request(sample_req(-32768, 32767));
    send_request(sample_req(0, 0));
    send_request(sample_req(1, -1));
    send_request(sample_req(-32768, -32768));
    send_request(sample_req(32767, 32767));
    send_request(coef_req(0, -32768));
    send_request(sample_req(-32768, -32768));
    send_request(sample_req(-1, 1));
    send_request(sample_req(16384, -16384));
    send_request(sample_req(32767, -32768));
    send_request(sample_req(-32768, 32767));
    // this sample completes the third block of four
    send_request(sample_req(100, -100));
    wait_idle();

    // random phases across tap count settings
    foreach (settings[i]) begin
      write_tap_count(settings[i]);
      random_requests(RANDOM_ITEMS / 6);
      wait_idle();
    end

    if (filt_sb.errors == 0 && filt_sb.pending.size() == 0) begin
      $display("overlap_add_fir_filter: match");
    end else begin
      $display("overlap_add_fir_filter: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
